// File: sv/triangular_alpha_cut_sampler_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef TRIANGULAR_ALPHA_CUT_SAMPLER_UNIT_DEFINES_SVH
`define TRIANGULAR_ALPHA_CUT_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TACS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tacs: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define TACS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tacs: next-cycle implication failed");

`endif

// File: sv/tacs_pkg.sv
package tacs_pkg;

	localparam int ALPHA_W   = 17;
	localparam int COUNT_W   = 7;
	localparam int POINT_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int ALU_W     = 51;
	localparam int SPAN_W    = 33;
	localparam int STEP_W    = 34;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_SAMPLES_DEF = 64;

	localparam logic [ALPHA_W-1:0]   ALPHA_ONE = ALPHA_W'(1 << FRAC_W);
	localparam logic [FRAC_W-1:0]    ROUND_ADJ = '1;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PEAK  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT = CFG_IDX_W'(2);

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] left_point;
		logic signed [POINT_W-1:0] peak_point;
		logic signed [POINT_W-1:0] right_point;
	} shape_t;

endpackage

// File: sv/tacs_chan_if.sv
interface tacs_in_if import tacs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ALPHA_W-1:0] alpha_level;
	logic [COUNT_W-1:0] sample_count;

	modport source(output valid, alpha_level, sample_count, input ready);
	modport sink(input valid, alpha_level, sample_count, output ready);
endinterface

interface tacs_out_if import tacs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [POINT_W-1:0] cut_point;
	logic                      last_point;

	modport source(output valid, cut_point, last_point, input ready);
	modport sink(input valid, cut_point, last_point, output ready);
endinterface

interface tacs_cfg_if import tacs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [POINT_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/tacs_alu.sv
module tacs_alu import tacs_pkg::*; (
	input  alu_op_t                 op,
	input  logic signed [ALU_W-1:0] opa,
	input  logic signed [ALU_W-1:0] opb,
	output logic signed [ALU_W-1:0] res
);

	always_comb begin
		unique case (op)
			ALU_ADD: res = opa + opb;
			ALU_SUB: res = opa - opb;
			default: res = opa + opb;
		endcase
	end

endmodule

// File: sv/tacs_ctrl.sv
module tacs_ctrl import tacs_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [ALPHA_W-1:0]        alpha_level,
	input  logic [COUNT_W-1:0]        sample_count,
	input  shape_t                    shape,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic signed [POINT_W-1:0] cut_point,
	output logic                      last_point
);

	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam int DW = $clog2(MAX_SAMPLES);
	localparam int AIW = $clog2(FRAC_W);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_RND,
		ST_FIN,
		ST_SPAN,
		ST_ABS,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic                      ph_q;
	logic [FRAC_W-1:0]         a_q;
	logic [NW-1:0]             n_q;
	logic [NW-1:0]             idx_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SPAN_W-1:0]  diff_q;
	logic signed [ALU_W-1:0]   acc_q;
	logic signed [POINT_W-1:0] end_q;
	logic signed [POINT_W-1:0] pt_q;
	logic signed [STEP_W-1:0]  step_q;
	logic                      neg_q;
	logic [DW-1:0]             rem_q;
	logic [SPAN_W-1:0]         dvd_q;
	logic                      res_valid_q;
	logic signed [POINT_W-1:0] cut_point_q;
	logic                      last_point_q;

	alu_op_t                   op;
	logic signed [ALU_W-1:0]   opa;
	logic signed [ALU_W-1:0]   opb;
	logic signed [ALU_W-1:0]   res;
	logic [NW-1:0]             n_nxt;
	logic [DW-1:0]             dvs;
	logic [DW:0]               rem_sh;
	logic signed [POINT_W-1:0] sat_res;
	logic                      is_last;
	logic                      slot_free;

	function automatic logic signed [POINT_W-1:0] sat32(input logic signed [ALU_W-1:0] v);
		logic signed [POINT_W-1:0] r;
		if (!v[ALU_W-1] && (|v[ALU_W-2:POINT_W-1]))
			r = {1'b0, {(POINT_W-1){1'b1}}};
		else if (v[ALU_W-1] && !(&v[ALU_W-2:POINT_W-1]))
			r = {1'b1, {(POINT_W-1){1'b0}}};
		else
			r = v[POINT_W-1:0];
		return r;
	endfunction

	tacs_alu u_alu (
		.op  (op),
		.opa (opa),
		.opb (opb),
		.res (res)
	);

	always_comb begin
		if (sample_count == '0)
			n_nxt = NW'(1);
		else if (32'(sample_count) > MAX_SAMPLES)
			n_nxt = NW'(MAX_SAMPLES);
		else
			n_nxt = NW'(sample_count);
	end

	assign dvs       = DW'(n_q - NW'(1));
	assign rem_sh    = {rem_q, dvd_q[SPAN_W-1]};
	assign sat_res   = sat32(res);
	assign is_last   = (idx_q == NW'(n_q - NW'(1)));
	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		op  = ALU_ADD;
		opa = acc_q;
		opb = '0;
		unique case (state_q)
			ST_DIFF: begin
				op  = ALU_SUB;
				opa = ph_q ? ALU_W'(shape.right_point) : ALU_W'(shape.peak_point);
				opb = ph_q ? ALU_W'(shape.peak_point) : ALU_W'(shape.left_point);
			end
			ST_MUL: begin
				opa = acc_q <<< 1;
				opb = a_q[cnt_q[AIW-1:0]] ? ALU_W'(diff_q) : '0;
			end
			ST_RND: begin
				opb = acc_q[ALU_W-1] ? signed'(ALU_W'(ROUND_ADJ)) : '0;
			end
			ST_FIN: begin
				op  = ph_q ? ALU_SUB : ALU_ADD;
				opa = ph_q ? ALU_W'(shape.right_point) : ALU_W'(shape.left_point);
				opb = acc_q >>> FRAC_W;
			end
			ST_SPAN: begin
				op  = ALU_SUB;
				opa = ALU_W'(end_q);
				opb = ALU_W'(pt_q);
			end
			ST_ABS: begin
				op  = ALU_SUB;
				opa = '0;
				opb = acc_q;
			end
			ST_DIV: begin
				op  = ALU_SUB;
				opa = signed'(ALU_W'(rem_sh));
				opb = signed'(ALU_W'(dvs));
			end
			ST_SIGN: begin
				op  = ALU_SUB;
				opa = '0;
				opb = signed'(ALU_W'(dvd_q));
			end
			ST_EMIT: begin
				opa = ALU_W'(pt_q);
				opb = ALU_W'(step_q);
			end
			default: begin
				op = ALU_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			ph_q        <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			n_q         <= NW'(1);
		end else begin
			res_valid_q <= ((state_q == ST_EMIT) && slot_free) || (res_valid_q && !res_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						idx_q <= '0;
						if (alpha_level >= ALPHA_ONE) begin
							end_q   <= shape.peak_point;
							n_q     <= NW'(1);
							state_q <= ST_EMIT;
						end else begin
							a_q     <= alpha_level[FRAC_W-1:0];
							n_q     <= n_nxt;
							ph_q    <= 1'b0;
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF: begin
					diff_q  <= res[SPAN_W-1:0];
					acc_q   <= '0;
					cnt_q   <= CNT_W'(FRAC_W - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q <= res;
					if (cnt_q == '0)
						state_q <= ST_RND;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				ST_RND: begin
					acc_q   <= res;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!ph_q) begin
						pt_q <= sat_res;
						if (n_q == NW'(1)) begin
							end_q   <= sat_res;
							state_q <= ST_EMIT;
						end else begin
							ph_q    <= 1'b1;
							state_q <= ST_DIFF;
						end
					end else begin
						end_q   <= sat_res;
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					acc_q   <= res;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					neg_q   <= acc_q[ALU_W-1];
					dvd_q   <= acc_q[ALU_W-1] ? res[SPAN_W-1:0] : acc_q[SPAN_W-1:0];
					rem_q   <= '0;
					cnt_q   <= CNT_W'(SPAN_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!res[ALU_W-1]) begin
						rem_q <= res[DW-1:0];
						dvd_q <= {dvd_q[SPAN_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[DW-1:0];
						dvd_q <= {dvd_q[SPAN_W-2:0], 1'b0};
					end
					if (cnt_q == '0)
						state_q <= ST_SIGN;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				ST_SIGN: begin
					step_q  <= neg_q ? res[STEP_W-1:0] : signed'(STEP_W'(dvd_q));
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						cut_point_q  <= is_last ? end_q : pt_q;
						last_point_q <= is_last;
						pt_q         <= res[POINT_W-1:0];
						idx_q        <= idx_q + NW'(1);
						if (is_last)
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign cut_point  = cut_point_q;
	assign last_point = last_point_q;

endmodule

// File: sv/triangular_alpha_cut_sampler_unit.sv
// channel  dir  word
// item     in   alpha_level[16:0], sample_count[6:0]
// result   out  cut_point[31:0] signed, last_point
// cfg      in   index[1:0] (0 left, 1 peak, 2 right), data[31:0]
//
// One request runs through a single shared add/sub unit: two 16-step shift-add
// multiplies for the cut ends, a 33-step restoring divide for the step, then
// one point per cycle while result is taken.
// Alpha of one emits the peak at once; a count of one needs only the left-end multiply.
// item.ready is high only between requests; result stalls hold the sequencer in its emit state.
// Reset clears the triangle registers to zero and the sequencer to idle.
module triangular_alpha_cut_sampler_unit import tacs_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	tacs_in_if.sink       item,
	tacs_out_if.source    result,
	tacs_cfg_if.sink      cfg
);

	shape_t shape_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEFT:  shape_q.left_point  <= cfg.data;
				REG_PEAK:  shape_q.peak_point  <= cfg.data;
				REG_RIGHT: shape_q.right_point <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	tacs_ctrl #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.alpha_level  (item.alpha_level),
		.sample_count (item.sample_count),
		.shape        (shape_q),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.cut_point    (result.cut_point),
		.last_point   (result.last_point)
	);

endmodule

// File: sv/tacs_check.sv
`include "triangular_alpha_cut_sampler_unit_defines.svh"

module tacs_check import tacs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [POINT_W-1:0] res_point,
	input logic               res_last
);

	`TACS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, item_valid && item_ready, !item_ready)

	`TACS_ASSERT_IMP(a_idle_holds_last, clk, arst_n, res_valid && item_ready, res_last)

	`TACS_ASSERT_IMP(a_busy_mid_run, clk, arst_n, res_valid && !res_last, !item_ready)

	`TACS_ASSERT_NXT(a_stall_holds, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_point) && $stable(res_last))

endmodule

bind triangular_alpha_cut_sampler_unit tacs_check u_tacs_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_point  (result.cut_point),
	.res_last   (result.last_point)
);
